### design/packed_list_store_unit_assert.svh
// Assertion macros shared by the packed list store modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PACKED_LIST_STORE_UNIT_ASSERT_SVH
`define PACKED_LIST_STORE_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define PLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define PLS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/pls_pkg.sv
// Package for the packed list store: sizes, codes and the cell command struct.
// Used by pls_cell, pls_ctrl and packed_list_store_unit; depends on nothing.
`timescale 1ns / 1ps

package pls_pkg;

  localparam int Depth  = 1024;
  localparam int IdxW   = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int DataW  = 32;
  localparam int ActW   = 3;
  localparam int IndexW = 10;
  localparam int CfgW   = 11;
  localparam int CountW = 11;
  localparam int StatW  = 2;
  localparam int ProdW  = 2 * CfgW;
  localparam int InW    = 48;
  localparam int OutW   = 48;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_POP    = 3'd3,
    ACT_REMOVE = 3'd4
  } pls_action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } pls_status_e;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } pls_cfg_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             wr;        // load value into the cell at idx
    logic             shift;     // cells at idx and above take their upper neighbor
    logic             rd_load;   // every cell copies its entry into its read stage
    logic             rd_shift;  // read stages move one cell toward cell zero
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] value;
  } pls_cmd_t;

endpackage

### design/pls_cell.sv
// One cell of the list chain: holds one entry and one read-out stage.
// Depends on pls_pkg for the command struct and widths.
`timescale 1ns / 1ps

module pls_cell (
  input  logic                      clk_i,
  input  pls_pkg::pls_cmd_t         cmd_i,
  input  logic [pls_pkg::IdxW-1:0]  pos_i,
  input  logic [pls_pkg::DataW-1:0] next_data_i,
  input  logic [pls_pkg::DataW-1:0] next_rd_i,
  output logic [pls_pkg::DataW-1:0] data_o,
  output logic [pls_pkg::DataW-1:0] rd_o
);
  import pls_pkg::*;

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.wr && (pos_i == cmd_i.idx)) begin
      data_d = cmd_i.value;
    end else if (cmd_i.shift && (pos_i >= cmd_i.idx)) begin
      data_d = next_data_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (cmd_i.rd_load) begin
      rd_d = data_q;
    end else if (cmd_i.rd_shift) begin
      rd_d = next_rd_i;
    end
  end

  // Entries are undefined until written, so the cell carries no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

### design/pls_ctrl.sv
// Controller of the packed list store: configuration, count, request decode,
// read sequencing and the result register. Depends on pls_pkg and the assert header.
`timescale 1ns / 1ps
`include "packed_list_store_unit_assert.svh"

module pls_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [pls_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pls_pkg::ActW-1:0]  in_action_i,
  input  logic [pls_pkg::DataW-1:0] in_value_i,
  input  logic [pls_pkg::IndexW-1:0] in_index_i,
  output pls_pkg::pls_cmd_t         cmd_o,
  input  logic [pls_pkg::DataW-1:0] rd0_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pls_pkg::DataW-1:0] out_read_value_o,
  output logic [pls_pkg::StatW-1:0] out_status_o,
  output logic [pls_pkg::CountW-1:0] out_count_o,
  output logic                      out_empty_flag_o
);
  import pls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SHIFT = 2'b10
  } pls_state_e;

  pls_state_e        state_q, state_d;
  logic [CfgW-1:0]   rows_q, cols_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   steps_q, steps_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  rv_q, rv_d;
  pls_status_e       stat_q, stat_d;
  logic [CountW-1:0] cnt_out_q, cnt_out_d;
  logic              load;

  logic [ProdW-1:0]  prod;
  logic [CntW-1:0]   capacity;
  logic              full;
  logic              in_range;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(32);
      cols_q <= CfgW'(32);
    end else if (cfg_we_i) begin
      unique case (pls_cfg_e'(cfg_index_i))
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  assign prod     = ProdW'(rows_q) * ProdW'(cols_q);
  assign capacity = (prod > ProdW'(Depth)) ? CntW'(Depth) : prod[CntW-1:0];
  assign full     = (count_q >= capacity) || (count_q >= CntW'(Depth));
  assign in_range = CntW'(in_index_i) < count_q;

  // A new request waits until the controller is idle and the result register is free or being emptied.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    steps_d      = steps_q;
    load         = 1'b0;
    rv_d         = '0;
    stat_d       = STAT_OK;
    cmd_o        = '0;
    cmd_o.idx    = IdxW'(in_index_i);
    cmd_o.value  = in_value_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (in_action_i)
            ACT_APPEND: begin
              if (full) begin
                stat_d = STAT_FULL;
              end else begin
                cmd_o.wr  = 1'b1;
                cmd_o.idx = count_q[IdxW-1:0];
                count_d   = count_q + CntW'(1);
              end
            end
            ACT_READ: begin
              if (!in_range) begin
                stat_d = STAT_RANGE;
              end else begin
                // The entry ripples down to cell zero, one cell per cycle.
                load          = 1'b0;
                cmd_o.rd_load = 1'b1;
                steps_d       = IdxW'(in_index_i);
                state_d       = ST_SHIFT;
              end
            end
            ACT_WRITE: begin
              if (!in_range) begin
                stat_d = STAT_RANGE;
              end else begin
                cmd_o.wr = 1'b1;
              end
            end
            ACT_POP: begin
              if (count_q == '0) begin
                stat_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            ACT_REMOVE: begin
              if (!in_range) begin
                stat_d = STAT_RANGE;
              end else begin
                cmd_o.shift = 1'b1;
                count_d     = count_q - CntW'(1);
              end
            end
            default: begin
              stat_d = STAT_OK;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (steps_q != '0) begin
          cmd_o.rd_shift = 1'b1;
          steps_d        = steps_q - IdxW'(1);
        end else begin
          load    = 1'b1;
          rv_d    = rd0_i;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cnt_out_d   = CountW'(count_d);
  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rv_q      <= rv_d;
      stat_q    <= stat_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = rv_q;
  assign out_status_o     = stat_q;
  assign out_count_o      = cnt_out_q;
  assign out_empty_flag_o = (cnt_out_q == '0);

  `PLS_ASSERT_NEVER(a_count_bound, count_q > CntW'(Depth), "count exceeds depth")
  `PLS_ASSERT_NEVER(a_shift_out_free, (state_q == ST_SHIFT) && out_valid_q,
                    "result register busy during read sequence")
  `PLS_ASSERT(a_read_enters_shift,
              accept && (in_action_i == ACT_READ) && in_range |=> state_q == ST_SHIFT,
              "read in range did not start the read sequence")
  `PLS_ASSERT(a_pop_decrements,
              accept && (in_action_i == ACT_POP) && (count_q != '0) |=>
              count_q == $past(count_q) - CntW'(1),
              "pop did not decrement the count")

endmodule

### design/packed_list_store_unit.sv
// Top level of the packed list store: a chain of entry cells and its controller.
// Depends on pls_pkg, pls_cell and pls_ctrl.
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   action, value, index
//   m_axis    out        m_axis_tvalid / m_axis_tready   read_value, status, count, empty_flag
//   cfg       in         cfg_we_i (no wait)              row_count, column_count
//
// Append, write, pop, remove, spare codes and every failed request finish when taken;
// the result is registered and shown in the following cycle. A read in range loads
// the read stages, moves the entry down them one cell per cycle, then registers it.
// Reset clears the count and the handshake and sets 32 rows by 32 columns; entries
// stay undefined until written. A request is taken only once the result register is
// free or being emptied, and one request is in work at a time.
`timescale 1ns / 1ps

module packed_list_store_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [pls_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [2:0] action, [34:3] value, [44:35] index, [47:45] zero
  input  logic [pls_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [31:0] read_value, [33:32] status, [44:34] count, [45] empty_flag, [47:46] zero
  output logic [pls_pkg::OutW-1:0]  m_axis_tdata
);
  import pls_pkg::*;

  pls_cmd_t           cmd;
  logic [DataW-1:0]   cell_data [Depth];
  logic [DataW-1:0]   cell_rd   [Depth];
  logic [DataW-1:0]   read_value;
  logic [StatW-1:0]   status;
  logic [CountW-1:0]  count;
  logic               empty_flag;

  pls_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_action_i      (s_axis_tdata[ActW-1:0]),
    .in_value_i       (s_axis_tdata[ActW+DataW-1:ActW]),
    .in_index_i       (s_axis_tdata[ActW+DataW+IndexW-1:ActW+DataW]),
    .cmd_o            (cmd),
    .rd0_i            (cell_rd[0]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_read_value_o (read_value),
    .out_status_o     (status),
    .out_count_o      (count),
    .out_empty_flag_o (empty_flag)
  );

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == Depth - 1) begin : g_last
      pls_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .pos_i       (IdxW'(g)),
        .next_data_i ('0),
        .next_rd_i   ('0),
        .data_o      (cell_data[g]),
        .rd_o        (cell_rd[g])
      );
    end else begin : g_mid
      pls_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd),
        .pos_i       (IdxW'(g)),
        .next_data_i (cell_data[g+1]),
        .next_rd_i   (cell_rd[g+1]),
        .data_o      (cell_data[g]),
        .rd_o        (cell_rd[g])
      );
    end
  end

  assign m_axis_tdata = {(OutW - DataW - StatW - CountW - 1)'(0),
                         empty_flag, count, status, read_value};

endmodule

### dv/tb_packed_list_store_unit.sv
// Self-checking testbench for packed_list_store_unit: random stream stalls on
// both sides, a built-in list predictor and an in-order result scoreboard.
// Depends on pls_pkg and the packed_list_store_unit RTL.
`timescale 1ns / 1ps

module tb_packed_list_store_unit;
  import pls_pkg::*;

  localparam logic [ActW-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ActW-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam int IdlePct = 24;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [DataW-1:0]  value;
    logic [IndexW-1:0] index;
  } list_req_t;

  // Ordered to match the result bus from bit 45 down to bit 0.
  typedef struct packed {
    logic              empty;
    logic [CountW-1:0] count;
    pls_status_e       status;
    logic [DataW-1:0]  read_value;
  } list_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_ROWS;
  logic [CfgW-1:0]  cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [InW-1:0]   s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OutW-1:0]  m_tdata;

  // Predictor state and its copy of the configuration.
  logic [DataW-1:0]  list_mem [Depth];
  logic [CountW-1:0] list_count = '0;
  logic [CfgW-1:0]   rows_cfg = 11'd32;
  logic [CfgW-1:0]   cols_cfg = 11'd32;

  list_req_t    pending_q [$];
  list_result_t expected_q [$];
  list_req_t    req_on_bus;
  int           gen_count;
  int           fail_count = 0;
  int           cycle_no = 0;
  logic         calm;

  packed_list_store_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  // Both sides stop idling during one long window.
  assign calm = (cycle_no >= 1000) && (cycle_no < 8000);

  function automatic int list_capacity();
    logic [ProdW-1:0] prod;
    prod = ProdW'(rows_cfg) * ProdW'(cols_cfg);
    return (prod > Depth) ? Depth : int'(prod);
  endfunction

  function automatic list_result_t list_step(list_req_t req);
    list_result_t res;
    int i;
    res.read_value = '0;
    res.status     = STAT_OK;
    case (req.action)
      ACT_APPEND: begin
        if (list_count >= list_capacity()) begin
          res.status = STAT_FULL;
        end else begin
          list_mem[list_count[IdxW-1:0]] = req.value;
          list_count++;
        end
      end
      ACT_READ: begin
        if (req.index >= list_count) res.status = STAT_RANGE;
        else res.read_value = list_mem[req.index];
      end
      ACT_WRITE: begin
        if (req.index >= list_count) res.status = STAT_RANGE;
        else list_mem[req.index] = req.value;
      end
      ACT_POP: begin
        if (list_count == 0) res.status = STAT_EMPTY;
        else list_count--;
      end
      ACT_REMOVE: begin
        if (req.index >= list_count) begin
          res.status = STAT_RANGE;
        end else begin
          for (i = req.index; i + 1 < list_count; i++) list_mem[i] = list_mem[i + 1];
          list_count--;
        end
      end
      default: ;
    endcase
    res.count = list_count;
    res.empty = (list_count == 0);
    return res;
  endfunction

  // The prediction is made when the request is taken.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(list_step(req_on_bus));
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          req_on_bus <= pending_q[0];
          s_tdata    <= {3'b000, pending_q[0].index, pending_q[0].value, pending_q[0].action};
          s_tvalid   <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = list_result_t'(m_tdata[45:0]);
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value %h status %0d count %0d empty %0b",
                   $realtime, got.read_value, got.status, got.count, got.empty);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected value %h status %0d count %0d empty %0b",
                     $realtime, want.read_value, want.status, want.count, want.empty);
            $display("%0t:           got value %h status %0d count %0d empty %0b",
                     $realtime, got.read_value, got.status, got.count, got.empty);
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic queue_req(logic [ActW-1:0] action, logic [DataW-1:0] value,
                           logic [IndexW-1:0] index);
    list_req_t req;
    req.action = action;
    req.value  = value;
    req.index  = index;
    pending_q.push_back(req);
    // Track the count so that most indexes land inside the list.
    case (action)
      ACT_APPEND: if (gen_count < list_capacity()) gen_count++;
      ACT_POP:    if (gen_count > 0) gen_count--;
      ACT_REMOVE: if (index < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [DataW-1:0] random_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IndexW-1:0] random_index();
    if (gen_count > 0 && $urandom_range(99) < 80) return IndexW'($urandom_range(gen_count - 1));
    return IndexW'($urandom_range(Depth - 1));
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(pls_cfg_e reg_sel, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (reg_sel == CFG_ROWS) rows_cfg = data;
    else cols_cfg = data;
  endtask

  // One configuration, optionally filled to capacity, then a weighted random mix.
  task automatic run_phase(int rows, int cols, int n_items, bit fill,
                           int w_app, int w_rd, int w_wr, int w_pop, int w_rem);
    int pick;
    int k;
    write_cfg(CFG_ROWS, CfgW'(rows));
    write_cfg(CFG_COLS, CfgW'(cols));
    gen_count = int'(list_count);
    if (fill) begin
      while (gen_count < list_capacity()) queue_req(ACT_APPEND, random_value(), '0);
    end
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(w_app + w_rd + w_wr + w_pop + w_rem + 2);
      if (pick < w_app)
        queue_req(ACT_APPEND, random_value(), IndexW'($urandom));
      else if (pick < w_app + w_rd)
        queue_req(ACT_READ, $urandom, random_index());
      else if (pick < w_app + w_rd + w_wr)
        queue_req(ACT_WRITE, random_value(), random_index());
      else if (pick < w_app + w_rd + w_wr + w_pop)
        queue_req(ACT_POP, $urandom, IndexW'($urandom));
      else if (pick < w_app + w_rd + w_wr + w_pop + w_rem)
        queue_req(ACT_REMOVE, $urandom, random_index());
      else
        queue_req(ActW'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)), $urandom,
                  IndexW'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    logic [ActW-1:0] spare;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_count = 0;

    // Directed part under the reset configuration.
    queue_req(ACT_POP, '0, '0);
    queue_req(ACT_REMOVE, '0, '0);
    queue_req(ACT_READ, '0, '0);
    queue_req(ACT_WRITE, 32'h1111_1111, '0);
    for (spare = ACT_SPARE_FIRST; spare != '0; spare++) queue_req(spare, '1, '1);
    queue_req(ACT_APPEND, 32'h8000_0000, '1);
    queue_req(ACT_APPEND, 32'h7FFF_FFFF, '0);
    queue_req(ACT_APPEND, 32'h0000_0000, '0);
    queue_req(ACT_APPEND, 32'hFFFF_FFFF, '0);
    queue_req(ACT_READ, '0, 10'd0);
    queue_req(ACT_READ, '0, 10'd3);
    queue_req(ACT_READ, '0, 10'd1023);
    queue_req(ACT_WRITE, 32'h1234_5678, 10'd1);
    queue_req(ACT_WRITE, 32'h1234_5678, 10'd1023);
    queue_req(ACT_READ, '0, 10'd1);
    // Removing from the middle shifts the tail down; removing the last does not.
    queue_req(ACT_REMOVE, '0, 10'd1);
    queue_req(ACT_READ, '0, 10'd1);
    queue_req(ACT_REMOVE, '0, 10'd2);
    queue_req(ACT_POP, '0, '0);
    queue_req(ACT_POP, '0, '0);
    queue_req(ACT_POP, '0, '0);
    wait_drained();

    run_phase(2, 3, 45, 1'b0, 40, 20, 15, 15, 10);
    run_phase(1024, 0, 20, 1'b0, 40, 15, 15, 15, 15);
    run_phase(0, 1024, 15, 1'b0, 40, 15, 15, 15, 15);
    run_phase(1, 1, 25, 1'b0, 35, 20, 15, 15, 15);
    run_phase(5, 7, 65, 1'b0, 40, 20, 15, 10, 15);
    run_phase(1024, 1024, 25, 1'b1, 20, 25, 20, 10, 25);
    // Capacity now far below the count: every append should fail as full.
    run_phase(3, 4, 25, 1'b0, 20, 25, 20, 15, 20);
    run_phase(1024, 1, 65, 1'b0, 5, 15, 15, 50, 15);
    run_phase(9, 1024, 55, 1'b0, 30, 20, 20, 15, 15);

    // A read deep in the list must ripple through nearly the whole chain of read stages.
    repeat (1100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[packed_list_store_unit] OK");
    end else begin
      $display("[packed_list_store_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[packed_list_store_unit] ERROR");
    $finish;
  end

endmodule
